// File: design/nrdb_pkg.sv
// Shared types, widths and constants of the neighbor-rank duty balancer.
// Holds the tanh node table, built at elaboration from an integer series.
// No dependencies; every other design file imports this package.
package nrdb_pkg;

    // tanh table: nodes at |x| = 4k/N, k = 0..N
    localparam int unsigned TANH_TABLE_ENTRIES = 64;
    localparam int unsigned TANH_IDX_W         = $clog2(TANH_TABLE_ENTRIES);
    localparam int unsigned TANH_ROM_AW        = $clog2(TANH_TABLE_ENTRIES + 1);
    localparam int unsigned TANH_W             = 17;
    localparam logic [TANH_W-1:0] TANH_ONE     = 17'h10000;

    // argument x = |current| * inverse scale, 2^-18 units; 4.0 = 2^20
    localparam int unsigned ARG_W       = 32;
    localparam int unsigned ARG_FRAC_W  = 20;
    localparam int unsigned TANH_POS_W  = ARG_FRAC_W + TANH_IDX_W;

    // datapath widths
    localparam int unsigned DATA_W  = 16;
    localparam int unsigned EMAG_W  = 17;
    localparam int unsigned GE_W    = DATA_W + EMAG_W;
    localparam int unsigned M1_W    = 25;
    localparam int unsigned M2_W    = 17;

    // configuration port
    localparam int unsigned APB_AW  = 5;
    localparam int unsigned APB_DW  = 32;

    localparam logic [63:0] Q31_ONE = 64'h0000_0000_8000_0000;

    typedef enum logic [2:0] {
        REG_DUTY_REFERENCE     = 3'd0,
        REG_VOLTAGE_GAIN       = 3'd1,
        REG_RANK_GAIN          = 3'd2,
        REG_ERROR_DEADBAND     = 3'd3,
        REG_CURRENT_INV_SCALE  = 3'd4
    } t_reg_idx;

    // number of ring neighbors whose voltage lies below our own
    typedef enum logic [1:0] {
        RANK_LOW  = 2'd0,
        RANK_MID  = 2'd1,
        RANK_HIGH = 2'd2
    } t_rank;

    typedef struct packed {
        logic [DATA_W-1:0] duty_reference;
        logic [DATA_W-1:0] voltage_gain;
        logic [DATA_W-1:0] rank_gain;
        logic [DATA_W-1:0] error_deadband;
        logic [DATA_W-1:0] current_inverse_scale;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        duty_reference:        16'd32768,
        voltage_gain:          16'd13107,
        rank_gain:             16'd1311,
        error_deadband:        16'd26,
        current_inverse_scale: 16'd256
    };

    // per-sample sign and rank info carried beside the tanh pipeline
    typedef struct packed {
        logic  cons_neg;
        logic  cur_neg;
        t_rank rank;
    } t_side;

    typedef logic [TANH_W-1:0] t_tanh_rom [0:TANH_TABLE_ENTRIES];

    // restoring division, used only while building the table
    function automatic logic [63:0] rom_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        int          b;
        quo = '0;
        rem = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-f) in Q31 for 0 <= f < 1, truncated power series
    function automatic logic [63:0] rom_exp_neg(input logic [63:0] f);
        logic [63:0]        term;
        logic signed [63:0] acc;
        int                 j;
        term = Q31_ONE;
        acc  = signed'(Q31_ONE);
        for (j = 1; j <= 24; j++) begin
            term = rom_udiv((term * f) >> 31, 64'(j));
            if (j[0]) begin
                acc = acc - signed'(term);
            end else begin
                acc = acc + signed'(term);
            end
        end
        if (acc < 0) begin
            acc = '0;
        end
        if (acc > signed'(Q31_ONE)) begin
            acc = signed'(Q31_ONE);
        end
        return unsigned'(acc);
    endfunction

    // tanh(4k/N) = (1 - e) / (1 + e), e = exp(-k/N)^8, rounded to Q0.16
    function automatic t_tanh_rom build_tanh_rom();
        t_tanh_rom   rom;
        logic [63:0] f;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] quo;
        int          k;
        int          s;
        rom[0] = '0;
        for (k = 1; k < TANH_TABLE_ENTRIES; k++) begin
            f = rom_udiv(64'(k) << 31, 64'(TANH_TABLE_ENTRIES));
            e = rom_exp_neg(f);
            for (s = 0; s < 3; s++) begin
                e = (e * e) >> 31;
            end
            den    = Q31_ONE + e;
            num    = ((Q31_ONE - e) << 16) + (den >> 1);
            quo    = rom_udiv(num, den);
            rom[k] = quo[TANH_W-1:0];
        end
        rom[TANH_TABLE_ENTRIES] = TANH_ONE;
        return rom;
    endfunction

    localparam t_tanh_rom TANH_ROM = build_tanh_rom();

endpackage

// File: design/neighbor_rank_duty_balancer_core.sv
// Neighbor-rank duty balancer: a six-stage pipeline that takes one sample per clock
// while o_s_axis_tready is high and holds all stages while it is low. The stages are input
// error and argument product, tanh node fetch, interpolation, gain products, consensus
// add with clamp, then rank add with clamp into the output; the per-stage multipliers
// set the clock. A one-entry skid behind the output register lets the pipeline keep
// running into a stall of the output; tready drops only once that entry is full.
// Registers are written over APB and should change only while no sample is in flight.
// Depends on nrdb_pkg and the nrdb_* submodules.
module neighbor_rank_duty_balancer_core import nrdb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // sample stream
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [15:0] current, [31:16] own_voltage, [47:32] prev_voltage, [63:48] next_voltage
    input  logic [63:0]       i_s_axis_tdata,
    // duty stream
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // [15:0] duty
    output logic [15:0]       o_m_axis_tdata,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int unsigned NSTAGE = 5;

    t_cfg cfg;
    logic en;
    logic accept;
    logic push;

    logic [DATA_W-1:0] cur_raw;
    logic [DATA_W-1:0] own_voltage;
    logic [DATA_W-1:0] prev_voltage;
    logic [DATA_W-1:0] next_voltage;

    logic [DATA_W-1:0]     cur_mag;
    logic signed [18:0]    err2;
    logic [18:0]           err2_abs;
    logic [EMAG_W-1:0]     emag;
    logic [1:0]            below_cnt;
    t_side                 side_a;

    logic [NSTAGE-1:0] r_vld;
    logic [ARG_W-1:0]  r_a_arg;
    logic [EMAG_W-1:0] r_a_emag;
    t_side             r_a_side;
    logic [GE_W-1:0]   r_b_ge;
    t_side             r_b_side;
    logic [GE_W-1:0]   r_c_ge;
    t_side             r_c_side;

    logic [TANH_W-1:0] c_tanh;
    logic [DATA_W-1:0] duty;

    nrdb_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign o_s_axis_tready = en;
    assign accept          = i_s_axis_tvalid && en;
    assign push            = en && r_vld[NSTAGE-1];

    assign cur_raw      = i_s_axis_tdata[15:0];
    assign own_voltage  = i_s_axis_tdata[31:16];
    assign prev_voltage = i_s_axis_tdata[47:32];
    assign next_voltage = i_s_axis_tdata[63:48];

    // stage A inputs: current magnitude, neighbor error with deadband, rank
    always_comb begin
        cur_mag   = cur_raw[DATA_W-1] ? DATA_W'(-cur_raw) : cur_raw;
        err2      = $signed(19'(prev_voltage)) + $signed(19'(next_voltage))
                  - $signed({2'b00, own_voltage, 1'b0});
        err2_abs  = err2[18] ? 19'(-err2) : 19'(err2);
        emag      = err2_abs[EMAG_W-1:0];
        if (emag < {cfg.error_deadband, 1'b0}) begin
            emag = '0;
        end
        below_cnt = 2'(own_voltage > prev_voltage) + 2'(own_voltage > next_voltage);
        side_a.cons_neg = err2[18] != cur_raw[DATA_W-1];
        side_a.cur_neg  = cur_raw[DATA_W-1];
        side_a.rank     = t_rank'(below_cnt);
    end

    // advance valid bits together with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTAGE-2:0], accept};
        end
    end

    // stages A to C of the side-band and voltage-gain product
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_arg  <= ARG_W'(cur_mag) * ARG_W'(cfg.current_inverse_scale);
            r_a_emag <= emag;
            r_a_side <= side_a;
            r_b_ge   <= GE_W'(cfg.voltage_gain) * GE_W'(r_a_emag);
            r_b_side <= r_a_side;
            r_c_ge   <= r_b_ge;
            r_c_side <= r_b_side;
        end
    end

    nrdb_tanh_interp u_tanh (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_arg  (r_a_arg),
        .o_tanh (c_tanh)
    );

    nrdb_duty_mix u_mix (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_cfg  (cfg),
        .i_ge   (r_c_ge),
        .i_tanh (c_tanh),
        .i_side (r_c_side),
        .o_duty (duty)
    );

    nrdb_out_skid u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (duty),
        .o_space  (en),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata)
    );

`ifndef SYNTHESIS
    // a full skid entry implies a waiting output
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("skid entry full without a pending output");

    // a result leaving the last stage shows up on the output
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_m_axis_tvalid)
        else $error("result from last stage lost");

    // tanh magnitude never exceeds one
    a_tanh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (c_tanh <= TANH_ONE))
        else $error("tanh magnitude above one");

    // pipeline holds while the skid entry is occupied
    a_hold_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |=> $stable(r_vld))
        else $error("pipeline moved while output side full");
`endif

endmodule

// File: design/nrdb_apb_regs.sv
// APB configuration registers of the duty balancer.
// Depends on nrdb_pkg for the register map and reset values.
module nrdb_apb_regs import nrdb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_sel;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    // write on the access phase; unmapped addresses drop the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_DUTY_REFERENCE:    r_cfg.duty_reference        <= pwdata[DATA_W-1:0];
                REG_VOLTAGE_GAIN:      r_cfg.voltage_gain          <= pwdata[DATA_W-1:0];
                REG_RANK_GAIN:         r_cfg.rank_gain             <= pwdata[DATA_W-1:0];
                REG_ERROR_DEADBAND:    r_cfg.error_deadband        <= pwdata[DATA_W-1:0];
                REG_CURRENT_INV_SCALE: r_cfg.current_inverse_scale <= pwdata[DATA_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_sel)
            REG_DUTY_REFERENCE:    prdata = APB_DW'(r_cfg.duty_reference);
            REG_VOLTAGE_GAIN:      prdata = APB_DW'(r_cfg.voltage_gain);
            REG_RANK_GAIN:         prdata = APB_DW'(r_cfg.rank_gain);
            REG_ERROR_DEADBAND:    prdata = APB_DW'(r_cfg.error_deadband);
            REG_CURRENT_INV_SCALE: prdata = APB_DW'(r_cfg.current_inverse_scale);
            default:               prdata = '0;
        endcase
    end

endmodule

// File: design/nrdb_tanh_interp.sv
// Two-stage tanh lookup with linear interpolation, saturating at 1.0.
// Depends on nrdb_pkg for the node table and argument format.
module nrdb_tanh_interp import nrdb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [ARG_W-1:0]  i_arg,
    output logic [TANH_W-1:0] o_tanh
);

    logic [TANH_POS_W-1:0]  pos;
    logic [TANH_IDX_W-1:0]  idx;
    logic [TANH_ROM_AW-1:0] addr_lo;
    logic [TANH_ROM_AW-1:0] addr_hi;
    logic [TANH_W-1:0]      node_lo;
    logic [TANH_W-1:0]      node_hi;
    logic                   arg_sat;

    logic                   r_sat;
    logic [TANH_W-1:0]      r_lo;
    logic [TANH_W-1:0]      r_diff;
    logic [ARG_FRAC_W-1:0]  r_frac;

    logic [TANH_W+ARG_FRAC_W-1:0] step;

    // split the scaled argument into node index and fraction
    assign arg_sat = |i_arg[ARG_W-1:ARG_FRAC_W];
    assign pos     = TANH_POS_W'(i_arg[ARG_FRAC_W-1:0]) * TANH_POS_W'(TANH_TABLE_ENTRIES);
    assign idx     = pos[TANH_POS_W-1:ARG_FRAC_W];
    assign addr_lo = TANH_ROM_AW'(idx);
    assign addr_hi = addr_lo + TANH_ROM_AW'(1);
    assign node_lo = TANH_ROM[addr_lo];
    assign node_hi = TANH_ROM[addr_hi];

    // stage: node fetch
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat  <= arg_sat;
            r_lo   <= node_lo;
            r_diff <= (node_hi > node_lo) ? (node_hi - node_lo) : '0;
            r_frac <= pos[ARG_FRAC_W-1:0];
        end
    end

    // stage: interpolate
    assign step = (TANH_W + ARG_FRAC_W)'(r_diff) * (TANH_W + ARG_FRAC_W)'(r_frac);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_tanh <= r_sat ? TANH_ONE
                            : r_lo + step[TANH_W+ARG_FRAC_W-1:ARG_FRAC_W];
        end
    end

endmodule

// File: design/nrdb_duty_mix.sv
// Consensus and rank terms, two saturating duty adds.
// Depends on nrdb_pkg for the side-band struct, rank codes and config.
module nrdb_duty_mix import nrdb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  t_cfg              i_cfg,
    input  logic [GE_W-1:0]   i_ge,
    input  logic [TANH_W-1:0] i_tanh,
    input  t_side             i_side,
    output logic [DATA_W-1:0] o_duty
);

    localparam int unsigned P1_W = GE_W + TANH_W;
    localparam int unsigned P2_W = DATA_W + TANH_W;

    logic [P1_W-1:0] prod1;
    logic [P2_W-1:0] prod2;

    logic [M1_W-1:0] r_d_m1;
    logic [M2_W-1:0] r_d_m2;
    t_side           r_d_side;

    logic signed [M1_W+1:0] sum1;
    logic [DATA_W-1:0]      d1;

    logic [DATA_W-1:0] r_e_d1;
    logic [M2_W-1:0]   r_e_m2;
    t_side             r_e_side;

    logic signed [M2_W+1:0] sum2;

    // stage: gain products
    assign prod1 = P1_W'(i_ge) * P1_W'(i_tanh);
    assign prod2 = P2_W'(i_cfg.rank_gain) * P2_W'(i_tanh);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_m1   <= prod1[P1_W-1:25];
            r_d_m2   <= prod2[P2_W-1:16];
            r_d_side <= i_side;
        end
    end

    // stage: reference plus or minus consensus term, clamp
    always_comb begin
        if (r_d_side.cons_neg) begin
            sum1 = $signed((M1_W+2)'(i_cfg.duty_reference)) - $signed((M1_W+2)'(r_d_m1));
        end else begin
            sum1 = $signed((M1_W+2)'(i_cfg.duty_reference)) + $signed((M1_W+2)'(r_d_m1));
        end
        if (sum1 < 0) begin
            d1 = '0;
        end else if (sum1 > $signed((M1_W+2)'(16'hFFFF))) begin
            d1 = '1;
        end else begin
            d1 = sum1[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_d1   <= d1;
            r_e_m2   <= r_d_m2;
            r_e_side <= r_d_side;
        end
    end

    // rank correction: no neighbor below pushes up, both below push down; reversed for negative current
    always_comb begin
        case (r_e_side.rank)
            RANK_LOW: begin
                sum2 = r_e_side.cur_neg ? $signed((M2_W+2)'(r_e_d1)) - $signed((M2_W+2)'(r_e_m2))
                                        : $signed((M2_W+2)'(r_e_d1)) + $signed((M2_W+2)'(r_e_m2));
            end
            RANK_HIGH: begin
                sum2 = r_e_side.cur_neg ? $signed((M2_W+2)'(r_e_d1)) + $signed((M2_W+2)'(r_e_m2))
                                        : $signed((M2_W+2)'(r_e_d1)) - $signed((M2_W+2)'(r_e_m2));
            end
            default: sum2 = $signed((M2_W+2)'(r_e_d1));
        endcase
        if (sum2 < 0) begin
            o_duty = '0;
        end else if (sum2 > $signed((M2_W+2)'(16'hFFFF))) begin
            o_duty = '1;
        end else begin
            o_duty = sum2[DATA_W-1:0];
        end
    end

endmodule

// File: design/nrdb_out_skid.sv
// Output register with one skid entry for the result stream.
// Depends on nrdb_pkg for the data width.
module nrdb_out_skid import nrdb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_space,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [DATA_W-1:0] o_tdata
);

    logic              r_out_vld;
    logic              r_skid_vld;
    logic [DATA_W-1:0] r_out_data;
    logic [DATA_W-1:0] r_skid_data;
    logic              stalled;

    assign stalled  = r_out_vld && !i_tready;
    assign o_space  = !r_skid_vld;
    assign o_tvalid = r_out_vld;
    assign o_tdata  = r_out_data;

    // control: park in the skid entry while the output is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (stalled) begin
            if (i_push) begin
                r_skid_vld <= 1'b1;
            end
        end else if (r_skid_vld) begin
            r_out_vld  <= 1'b1;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld <= i_push;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (stalled) begin
            if (i_push) begin
                r_skid_data <= i_data;
            end
        end else if (r_skid_vld) begin
            r_out_data <= r_skid_data;
        end else if (i_push) begin
            r_out_data <= i_data;
        end
    end

endmodule
